### design/btbtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbtl_pkg
// Shared types and constants of the two-level branch predictor with BTB.
// ----------------------------------------------------------------------------
package btbtl_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BTB_SIZE_LOG2   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_HISTORY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_TABLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_MODE      = 3'd6;

  // item kinds
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_UPDATE  = 1'b1;

  // shared table index mixing
  localparam logic [1:0] SHARE_NONE = 2'd0;
  localparam logic [1:0] SHARE_PC2  = 2'd1;
  localparam logic [1:0] SHARE_PC16 = 2'd2;

  // 2-bit saturating counter
  localparam logic [1:0] CTR_MIN = 2'd0;
  localparam logic [1:0] CTR_WT  = 2'd2;
  localparam logic [1:0] CTR_MAX = 2'd3;

  localparam int MAX_L_LIMIT = 5;
  localparam int ADDR_BITS   = 30;
  localparam int PC_STEP     = 4;
  localparam int SHARE_HI_LSB = 16;

  typedef struct packed {
    logic        kind;
    logic [31:0] pc;
    logic [31:0] target_pc;
    logic        taken;
    logic [31:0] earlier_prediction;
  } in_word_t;

  typedef struct packed {
    logic        predict_taken;
    logic [31:0] predicted_target;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
    logic [14:0] storage_bits;
  } out_word_t;

  // effective (saturated) configuration
  typedef struct packed {
    logic [2:0] log2;
    logic [3:0] hist;
    logic [4:0] tag;
    logic [1:0] init;
    logic       gh;
    logic       gt;
    logic [1:0] share;
  } eff_cfg_t;

endpackage

### design/btbtl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbtl_cfg
// Configuration registers, saturated working values and storage size.
// ----------------------------------------------------------------------------
module btbtl_cfg #(
  parameter int MAX_BTB_ENTRIES  = 32,
  parameter int MAX_HISTORY_BITS = 8,
  parameter int MAX_TAG_BITS     = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [btbtl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btbtl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output btbtl_pkg::eff_cfg_t                ecfg,
  output logic                               cfg_clr,
  output logic [14:0]                        storage_bits
);
  import btbtl_pkg::*;

  localparam int LOG2_MAX = $clog2(MAX_BTB_ENTRIES + 1) - 1;

  logic [2:0] size_r;
  logic [3:0] hist_r;
  logic [4:0] tag_r;
  logic [1:0] init_r;
  logic       gh_r;
  logic       gt_r;
  logic [1:0] share_r;

  always_comb begin
    case (cfg_index)
      REG_BTB_SIZE_LOG2, REG_HISTORY_BITS, REG_TAG_BITS, REG_INITIAL_COUNTER,
      REG_GLOBAL_HISTORY, REG_GLOBAL_TABLE, REG_SHARE_MODE: cfg_clr = cfg_we;
      default: cfg_clr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= 3'd0;
      hist_r  <= 4'd1;
      tag_r   <= 5'd0;
      init_r  <= 2'd1;
      gh_r    <= 1'b0;
      gt_r    <= 1'b0;
      share_r <= SHARE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BTB_SIZE_LOG2:   size_r  <= cfg_wdata[2:0];
        REG_HISTORY_BITS:    hist_r  <= cfg_wdata[3:0];
        REG_TAG_BITS:        tag_r   <= cfg_wdata[4:0];
        REG_INITIAL_COUNTER: init_r  <= cfg_wdata[1:0];
        REG_GLOBAL_HISTORY:  gh_r    <= cfg_wdata[0];
        REG_GLOBAL_TABLE:    gt_r    <= cfg_wdata[0];
        REG_SHARE_MODE:      share_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [2:0]  l0;
  logic [4:0]  tag_lim;
  logic [15:0] n_term;
  logic [15:0] h_term;
  logic [15:0] c_term;

  always_comb begin
    l0 = (size_r > 3'(MAX_L_LIMIT)) ? 3'(MAX_L_LIMIT) : size_r;
    ecfg.log2 = (l0 > 3'(LOG2_MAX)) ? 3'(LOG2_MAX) : l0;
    if (hist_r == 4'd0) begin
      ecfg.hist = 4'd1;
    end else if (hist_r > 4'(MAX_HISTORY_BITS)) begin
      ecfg.hist = 4'(MAX_HISTORY_BITS);
    end else begin
      ecfg.hist = hist_r;
    end
    tag_lim = 5'(ADDR_BITS) - 5'(ecfg.log2);
    if (tag_lim > 5'(MAX_TAG_BITS)) begin
      tag_lim = 5'(MAX_TAG_BITS);
    end
    ecfg.tag   = (tag_r > tag_lim) ? tag_lim : tag_r;
    ecfg.init  = init_r;
    ecfg.gh    = gh_r;
    ecfg.gt    = gt_r;
    ecfg.share = share_r;

    // entries * (tag + target + valid) + history bits + 2 * counters
    n_term = (16'(ecfg.tag) + 16'(ADDR_BITS + 1)) << ecfg.log2;
    h_term = ecfg.gh ? 16'(ecfg.hist) : (16'(ecfg.hist) << ecfg.log2);
    c_term = ecfg.gt ? (16'd2 << ecfg.hist) : (16'd2 << (5'(ecfg.hist) + 5'(ecfg.log2)));
    storage_bits = 15'(n_term + h_term + c_term);
  end

endmodule

### design/btbtl_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbtl_row_mem
// Counter row memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module btbtl_row_mem #(
  parameter int DEPTH = 33,
  parameter int WIDTH = 512,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/btb_two_level_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped BTB with two-level (history + 2-bit counter) direction
// prediction; global or per-entry history and counter tables.
// ----------------------------------------------------------------------------
// Takes one word per clock: a word is accepted when start is high and busy is
// low, and its result appears on out_word with out_valid high for exactly one
// cycle. The receiver cannot stall. The result passes through the input
// register with the counter-row memory read, then the result register;
// back-to-back words that hit the same counter row are forwarded. busy is
// high during reset and in the first cycle after it. A configuration write
// clears all predictor state and statistics in the same cycle, through
// per-row and per-entry valid bits, so no clearing pass is needed.
module btb_two_level_branch_predictor #(
  parameter int MAX_BTB_ENTRIES  = 32,
  parameter int MAX_HISTORY_BITS = 8,
  parameter int MAX_TAG_BITS     = 30
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  btbtl_pkg::in_word_t               in_word,
  output logic                              out_valid,
  output btbtl_pkg::out_word_t              out_word,
  input  logic                              cfg_we,
  input  logic [btbtl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btbtl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import btbtl_pkg::*;

  localparam int IDX_W = (MAX_BTB_ENTRIES > 1) ? $clog2(MAX_BTB_ENTRIES) : 1;
  localparam int ROWS  = MAX_BTB_ENTRIES + 1;
  localparam int RA_W  = $clog2(ROWS);
  localparam int HB    = MAX_HISTORY_BITS;
  localparam int NCTR  = 1 << HB;
  localparam int TAG_W = (MAX_TAG_BITS > 0) ? MAX_TAG_BITS : 1;
  localparam logic [RA_W-1:0] SHARED_ROW = RA_W'(MAX_BTB_ENTRIES);

  typedef logic [NCTR-1:0][1:0] row_t;

  eff_cfg_t    ecfg;
  logic        cfg_clr;
  logic [14:0] storage_bits;

  btbtl_cfg #(
    .MAX_BTB_ENTRIES  (MAX_BTB_ENTRIES),
    .MAX_HISTORY_BITS (MAX_HISTORY_BITS),
    .MAX_TAG_BITS     (MAX_TAG_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .ecfg         (ecfg),
    .cfg_clr      (cfg_clr),
    .storage_bits (storage_bits)
  );

  logic busy_r;
  logic accept;

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // ---------------- input stage ----------------
  logic [IDX_W-1:0] in_entry;
  logic [RA_W-1:0]  in_raddr;

  logic             s1_valid_r;
  in_word_t         s1_word_r;
  logic [IDX_W-1:0] s1_entry_r;
  logic [RA_W-1:0]  s1_raddr_r;
  logic             s1_rv_r;
  logic             s1_byp_r;
  row_t             s1_bypr_r;

  logic [ROWS-1:0]  rv_r;
  logic             row_wr;
  row_t             row_new;
  logic [2*NCTR-1:0] mem_rdata;

  assign in_entry = in_word.pc[2 +: IDX_W] & ~({IDX_W{1'b1}} << ecfg.log2);
  assign in_raddr = ecfg.gt ? SHARED_ROW : RA_W'(in_entry);
  assign row_wr   = s1_valid_r && (s1_word_r.kind == KIND_UPDATE);

  btbtl_row_mem #(
    .DEPTH (ROWS),
    .WIDTH (2 * NCTR),
    .AW    (RA_W)
  ) u_row_mem (
    .clk   (clk),
    .we    (row_wr),
    .waddr (s1_raddr_r),
    .wdata (row_new),
    .re    (accept),
    .raddr (in_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r  <= in_word;
      s1_entry_r <= in_entry;
      s1_raddr_r <= in_raddr;
      s1_rv_r    <= rv_r[in_raddr];
      // forward the row being written by the word ahead
      s1_byp_r   <= row_wr && (in_raddr == s1_raddr_r);
      s1_bypr_r  <= row_new;
    end
  end

  // ---------------- entry state ----------------
  logic             valid_r [MAX_BTB_ENTRIES];
  logic [TAG_W-1:0] tag_r   [MAX_BTB_ENTRIES];
  logic [31:0]      etgt_r  [MAX_BTB_ENTRIES];
  logic [HB-1:0]    ehist_r [MAX_BTB_ENTRIES];
  logic [HB-1:0]    shist_r;
  logic [31:0]      br_r;
  logic [31:0]      fl_r;

  // ---------------- predict / update logic ----------------
  row_t         init_row;
  row_t         row_cur;
  row_t         row_base;
  logic [HB-1:0] hmask;
  logic [TAG_W-1:0] s2_tag;
  logic         is_upd;
  logic         tag_hit;
  logic         tag_chg;
  logic         e_valid;
  logic [TAG_W-1:0] e_tag;
  logic [31:0]  e_tgt;
  logic [HB-1:0] e_hist;
  logic [HB-1:0] hist_base;
  logic [HB-1:0] hist_sel;
  logic [HB-1:0] mix;
  logic [HB-1:0] ctr_idx;
  logic [1:0]   ctr;
  logic [1:0]   ctr_nxt;
  logic [HB-1:0] hist_new;
  logic [HB-1:0] shist_new;
  logic [31:0]  fall;
  logic         flush;
  logic         pred_hit;
  logic [31:0]  br_nxt;
  logic [31:0]  fl_nxt;
  out_word_t    out_nxt;

  always_comb begin
    init_row = {NCTR{ecfg.init}};
    hmask    = ~({HB{1'b1}} << ecfg.hist);
    s2_tag   = TAG_W'((s1_word_r.pc[31:2] >> ecfg.log2) & ~({30{1'b1}} << ecfg.tag));
    is_upd   = (s1_word_r.kind == KIND_UPDATE);
    e_valid  = valid_r[s1_entry_r];
    e_tag    = tag_r[s1_entry_r];
    e_tgt    = etgt_r[s1_entry_r];
    e_hist   = ehist_r[s1_entry_r];
    tag_hit  = (e_tag == s2_tag);
    tag_chg  = is_upd && !tag_hit;

    row_cur   = s1_byp_r ? s1_bypr_r : (s1_rv_r ? row_t'(mem_rdata) : init_row);
    row_base  = (tag_chg && !ecfg.gt) ? init_row : row_cur;
    hist_base = (tag_chg && !ecfg.gh) ? '0 : e_hist;
    hist_sel  = (ecfg.gh ? shist_r : hist_base) & hmask;

    case (ecfg.share)
      SHARE_PC2:  mix = s1_word_r.pc[2 +: HB];
      SHARE_PC16: mix = s1_word_r.pc[SHARE_HI_LSB +: HB];
      default:    mix = '0;
    endcase
    ctr_idx = ecfg.gt ? (hist_sel ^ (mix & hmask)) : hist_sel;
    ctr     = row_base[ctr_idx];

    if (s1_word_r.taken) begin
      ctr_nxt = (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
    end else begin
      ctr_nxt = (ctr == CTR_MIN) ? ctr : ctr - 2'd1;
    end
    row_new          = row_base;
    row_new[ctr_idx] = ctr_nxt;

    hist_new  = HB'({hist_base, s1_word_r.taken}) & hmask;
    shist_new = HB'({shist_r, s1_word_r.taken}) & hmask;

    fall  = s1_word_r.pc + 32'(PC_STEP);
    flush = (s1_word_r.taken && ((s1_word_r.earlier_prediction == fall) ||
                                 (s1_word_r.earlier_prediction != s1_word_r.target_pc))) ||
            (!s1_word_r.taken && (s1_word_r.earlier_prediction != fall));

    br_nxt = br_r;
    fl_nxt = fl_r;
    if (is_upd) begin
      if (br_r != '1) begin
        br_nxt = br_r + 32'd1;
      end
      if (flush && (fl_r != '1)) begin
        fl_nxt = fl_r + 32'd1;
      end
    end

    pred_hit = e_valid && tag_hit && (ctr >= CTR_WT);

    out_nxt.predict_taken    = !is_upd && pred_hit;
    out_nxt.predicted_target = is_upd ? 32'd0 : (pred_hit ? e_tgt : fall);
    out_nxt.branch_count     = br_nxt;
    out_nxt.flush_count      = fl_nxt;
    out_nxt.storage_bits     = storage_bits;
  end

  // state write-back
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clr) begin
      rv_r    <= '0;
      shist_r <= '0;
      br_r    <= '0;
      fl_r    <= '0;
      for (int i = 0; i < MAX_BTB_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        tag_r[i]   <= '0;
        ehist_r[i] <= '0;
      end
    end else if (row_wr) begin
      rv_r[s1_raddr_r]    <= 1'b1;
      br_r                <= br_nxt;
      fl_r                <= fl_nxt;
      valid_r[s1_entry_r] <= 1'b1;
      tag_r[s1_entry_r]   <= s2_tag;
      if (ecfg.gh) begin
        shist_r <= shist_new;
      end else begin
        ehist_r[s1_entry_r] <= hist_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_wr) begin
      etgt_r[s1_entry_r] <= s1_word_r.target_pc;
    end
  end

  // ---------------- result register ----------------
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### design/btbtl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btbtl_checker
// Port-level checks of the branch predictor, bound to the top level.
// ----------------------------------------------------------------------------
module btbtl_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input btbtl_pkg::in_word_t   in_word,
  input logic                  out_valid,
  input btbtl_pkg::out_word_t  out_word
);
  import btbtl_pkg::*;

  // every accepted word gives a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word produced no result");

  // no result without an accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without accepted word");

  // update words report no prediction
  a_update_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_word.kind, 2) == KIND_UPDATE)
      |-> (!out_word.predict_taken && out_word.predicted_target == 32'd0))
    else $error("update word reported a prediction");

  // a flush is always a counted branch
  a_flush_le_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.flush_count <= out_word.branch_count))
    else $error("flush count above branch count");

endmodule

bind btb_two_level_branch_predictor btbtl_checker u_btbtl_checker (.*);

### tb/btb_two_level_branch_predictor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_tb
// Self-checking bench for the BTB with two-level direction prediction. A
// behavioral copy of the predictor tracks entries, histories, counters and
// statistics and computes the answer to every accepted word. Each result
// word is compared field by field with the oldest pending answer. Directed
// tests cover the reset settings, counter saturation, the flush rule, an
// out-of-range register write and tag replacement in every history/table
// mode. Random phases then sweep the settings, extremes included, with
// branch streams drawn from small address pools so that entries hit.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_tb;
  import btbtl_pkg::*;

  localparam int BTB_DEPTH     = 32;
  localparam int ROW_LEN       = 256;
  localparam int MAX_HIST      = 8;
  localparam int MAX_TAG       = 30;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_WORDS   = 95;
  localparam int POOL_MAX      = 24;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [1:0]           CTR_WNT    = 2'd1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  btb_two_level_branch_predictor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state and settings
  // --------------------------------------------------------------------------
  logic [2:0]  set_log2;
  logic [3:0]  set_hist;
  logic [4:0]  set_tag;
  logic [1:0]  set_init;
  logic        set_gh;
  logic        set_gt;
  logic [1:0]  set_share;

  logic        btb_valid  [BTB_DEPTH];
  logic [29:0] btb_tag    [BTB_DEPTH];
  logic [31:0] btb_target [BTB_DEPTH];
  logic [7:0]  entry_hist [BTB_DEPTH];
  logic [7:0]  shared_hist;
  logic [1:0]  shared_ctr [ROW_LEN];
  logic [1:0]  entry_ctr  [BTB_DEPTH*ROW_LEN];
  logic [31:0] branches;
  logic [31:0] flushes;

  out_word_t answer_q[$];
  int        mismatch_count;
  int        words_sent;
  int        results_checked;
  int        taken_answers;
  int        reg_writes;

  function automatic int unsigned eff_log2();
    return (set_log2 > MAX_L_LIMIT) ? MAX_L_LIMIT : set_log2;
  endfunction

  function automatic int unsigned eff_hist();
    int unsigned h;
    h = set_hist;
    if (h < 1) h = 1;
    if (h > MAX_HIST) h = MAX_HIST;
    return h;
  endfunction

  function automatic int unsigned eff_tag();
    int unsigned lim;
    lim = ADDR_BITS - eff_log2();
    if (lim > MAX_TAG) lim = MAX_TAG;
    return (set_tag > lim) ? lim : set_tag;
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < BTB_DEPTH; i++) begin
      btb_valid[i]  = 1'b0;
      btb_tag[i]    = '0;
      btb_target[i] = '0;
      entry_hist[i] = '0;
    end
    for (int i = 0; i < ROW_LEN; i++) shared_ctr[i] = set_init;
    for (int i = 0; i < BTB_DEPTH*ROW_LEN; i++) entry_ctr[i] = set_init;
    shared_hist = '0;
    branches    = '0;
    flushes     = '0;
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BTB_SIZE_LOG2:   set_log2  = data[2:0];
      REG_HISTORY_BITS:    set_hist  = data[3:0];
      REG_TAG_BITS:        set_tag   = data[4:0];
      REG_INITIAL_COUNTER: set_init  = data[1:0];
      REG_GLOBAL_HISTORY:  set_gh    = data[0];
      REG_GLOBAL_TABLE:    set_gt    = data[0];
      REG_SHARE_MODE:      set_share = data[1:0];
      default:             return;
    endcase
    clear_state();
  endfunction

  // Index of the selected counter: into shared_ctr when the table is
  // global, otherwise into the entry's row of entry_ctr.
  function automatic int unsigned counter_slot(input logic [31:0] pc,
                                               input int unsigned entry);
    logic [7:0] hmask;
    logic [7:0] hist;
    logic [7:0] mix;
    hmask = 8'((1 << eff_hist()) - 1);
    hist  = (set_gh ? shared_hist : entry_hist[entry]) & hmask;
    mix   = '0;
    if (set_gt) begin
      if (set_share == SHARE_PC2) mix = 8'(pc >> 2) & hmask;
      else if (set_share == SHARE_PC16) mix = 8'(pc >> SHARE_HI_LSB) & hmask;
      return int'(hist ^ mix);
    end
    return entry * ROW_LEN + hist;
  endfunction

  function automatic logic [14:0] storage_size();
    int unsigned n;
    int unsigned h;
    int unsigned hbits;
    int unsigned nctr;
    n     = 1 << eff_log2();
    h     = eff_hist();
    hbits = set_gh ? h : h * n;
    nctr  = set_gt ? (1 << h) : (1 << h) * n;
    return 15'(n * (eff_tag() + ADDR_BITS + 1) + hbits + nctr * 2);
  endfunction

  function automatic out_word_t compute_answer(input in_word_t w);
    int unsigned l;
    int unsigned t;
    int unsigned entry;
    int unsigned slot;
    logic [29:0] tag;
    logic [31:0] fall;
    logic [7:0]  hmask;
    logic [1:0]  ctr;
    out_word_t   r;
    l     = eff_log2();
    t     = eff_tag();
    entry = (w.pc >> 2) & ((32'd1 << l) - 1);
    tag   = 30'(((w.pc >> 2) >> l) & 32'((64'd1 << t) - 1));
    fall  = w.pc + 32'(PC_STEP);
    hmask = 8'((1 << eff_hist()) - 1);
    r     = '0;
    if (w.kind == KIND_PREDICT) begin
      r.predicted_target = fall;
      if (btb_valid[entry] && btb_tag[entry] == tag) begin
        slot = counter_slot(w.pc, entry);
        ctr  = set_gt ? shared_ctr[slot] : entry_ctr[slot];
        if (ctr >= CTR_WT) begin
          r.predict_taken    = 1'b1;
          r.predicted_target = btb_target[entry];
        end
      end
    end else begin
      if (branches != '1) branches++;
      if ((w.taken && (w.earlier_prediction == fall || w.earlier_prediction != w.target_pc)) ||
          (!w.taken && w.earlier_prediction != fall)) begin
        if (flushes != '1) flushes++;
      end
      btb_valid[entry]  = 1'b1;
      btb_target[entry] = w.target_pc;
      // tag compare ignores the valid bit
      if (tag != btb_tag[entry]) begin
        btb_tag[entry] = tag;
        if (!set_gt) begin
          for (int i = 0; i < ROW_LEN; i++) entry_ctr[entry*ROW_LEN + i] = set_init;
        end
        if (!set_gh) entry_hist[entry] = '0;
      end
      slot = counter_slot(w.pc, entry);
      ctr  = set_gt ? shared_ctr[slot] : entry_ctr[slot];
      if (w.taken) begin
        if (ctr != CTR_MAX) ctr++;
      end else if (ctr != CTR_MIN) begin
        ctr--;
      end
      if (set_gt) shared_ctr[slot] = ctr;
      else entry_ctr[slot] = ctr;
      if (set_gh) shared_hist = ((shared_hist << 1) | w.taken) & hmask;
      else entry_hist[entry] = ((entry_hist[entry] << 1) | w.taken) & hmask;
    end
    r.branch_count = branches;
    r.flush_count  = flushes;
    r.storage_bits = storage_size();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void report_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
    end
  endfunction

  function automatic void check_answer(input out_word_t exp_w, input out_word_t got_w);
    report_field("predict_taken",    32'(exp_w.predict_taken),    32'(got_w.predict_taken));
    report_field("predicted_target", exp_w.predicted_target,      got_w.predicted_target);
    report_field("branch_count",     exp_w.branch_count,          got_w.branch_count);
    report_field("flush_count",      exp_w.flush_count,           got_w.flush_count);
    report_field("storage_bits",     32'(exp_w.storage_bits),     32'(got_w.storage_bits));
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with nothing pending, expected none got %p",
                   $time, out_word);
        end else begin
          results_checked++;
          if (out_word.predict_taken === 1'b1) taken_answers++;
          check_answer(answer_q.pop_front(), out_word);
        end
      end
      if (cfg_we) apply_setting(cfg_index, cfg_wdata);
      if (start && !busy) begin
        answer_q.push_back(compute_answer(in_word));
        words_sent++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  function automatic in_word_t pack_word(input logic kind, input logic [31:0] pc,
                                         input logic [31:0] tgt, input logic taken,
                                         input logic [31:0] earlier);
    in_word_t w;
    w.kind               = kind;
    w.pc                 = pc;
    w.target_pc          = tgt;
    w.taken              = taken;
    w.earlier_prediction = earlier;
    return w;
  endfunction

  // Leave start high on return so back-to-back words stream.
  task automatic send_word(input in_word_t w);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic maybe_pause(input int pct);
    if (pct != 0 && $urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic load_settings(input logic [4:0] l, input logic [4:0] h,
                               input logic [4:0] t, input logic [4:0] init,
                               input logic [4:0] gh, input logic [4:0] gt,
                               input logic [4:0] share);
    drain();
    write_reg(REG_BTB_SIZE_LOG2, l);
    write_reg(REG_HISTORY_BITS, h);
    write_reg(REG_TAG_BITS, t);
    write_reg(REG_INITIAL_COUNTER, init);
    write_reg(REG_GLOBAL_HISTORY, gh);
    write_reg(REG_GLOBAL_TABLE, gt);
    write_reg(REG_SHARE_MODE, share);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_word(pack_word(KIND_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000));
    send_word(pack_word(KIND_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_word(pack_word(KIND_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000));
  endtask

  task automatic test_counter_saturation();
    load_settings(5'd3, 5'd2, 5'd8, 5'(CTR_MIN), 5'd1, 5'd1, 5'(SHARE_PC2));
    repeat (3) send_word(pack_word(KIND_UPDATE, 32'h0000_1040, 32'h0000_2000, 1'b1,
                                   32'h0000_2000));
    send_word(pack_word(KIND_PREDICT, 32'h0000_1040, 32'h0, 1'b0, 32'h0));
    send_word(pack_word(KIND_UPDATE, 32'h0000_1040, 32'h0000_2000, 1'b0, 32'h0000_1044));
  endtask

  task automatic test_flush_rule();
    logic [31:0] pc;
    logic [31:0] tgt;
    pc  = 32'h0000_2000;
    tgt = 32'h0000_3000;
    load_settings(5'd2, 5'd4, 5'd6, 5'(CTR_WNT), 5'd0, 5'd0, 5'(SHARE_NONE));
    send_word(pack_word(KIND_UPDATE, pc, tgt, 1'b1, pc + 32'(PC_STEP)));
    send_word(pack_word(KIND_UPDATE, pc, tgt, 1'b1, tgt));
    send_word(pack_word(KIND_UPDATE, pc, tgt, 1'b1, 32'hDEAD_BEE0));
    send_word(pack_word(KIND_UPDATE, pc, tgt, 1'b0, pc + 32'(PC_STEP)));
    send_word(pack_word(KIND_UPDATE, pc, tgt, 1'b0, tgt));
    // out-of-range index must leave state and statistics alone
    drain();
    write_reg(REG_UNUSED, 5'h1F);
    send_word(pack_word(KIND_PREDICT, pc, 32'h0, 1'b0, 32'h0));
  endtask

  task automatic test_tag_change_modes();
    logic [31:0] pc_a;
    logic [31:0] pc_b;
    pc_a = 32'h0000_0024;
    pc_b = pc_a ^ 32'h0000_0050;  // same entry, new tag
    for (int m = 0; m < 4; m++) begin
      load_settings(5'd2, 5'd3, 5'd4, 5'(CTR_WT), 5'(m & 1), 5'(m >> 1), 5'(SHARE_PC2));
      send_word(pack_word(KIND_UPDATE, pc_a, 32'h0000_4000, 1'b1, 32'h0000_4000));
      send_word(pack_word(KIND_UPDATE, pc_b, 32'h0000_5000, 1'b1, pc_b + 32'(PC_STEP)));
      send_word(pack_word(KIND_PREDICT, pc_b, 32'h0, 1'b0, 32'h0));
    end
  endtask

  // One settings phase: pools of branch addresses with fixed targets and a
  // taken bias, mixed with fully random words.
  task automatic run_phase(input int phase, input int items, input int pause_pct);
    logic [31:0] pc_pool  [POOL_MAX];
    logic [31:0] tgt_pool [POOL_MAX];
    int          bias     [POOL_MAX];
    int          pool_n;
    int          k;
    in_word_t    w;
    if (phase == 0) begin
      load_settings(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    end else if (phase == 1) begin
      load_settings(5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F, 5'h1F);
    end else begin
      load_settings(5'($urandom_range(0, 7)), 5'($urandom_range(0, 15)),
                    5'($urandom_range(0, 31)), 5'($urandom_range(0, 3)),
                    5'(phase & 1), 5'((phase >> 1) & 1), 5'((phase >> 2) & 3));
    end
    pool_n = $urandom_range(2, POOL_MAX);
    for (int i = 0; i < pool_n; i++) begin
      // some addresses alias an earlier entry with a different tag
      if (i > 0 && $urandom_range(0, 2) == 0)
        pc_pool[i] = pc_pool[$urandom_range(0, i - 1)] ^ ($urandom << 7);
      else
        pc_pool[i] = $urandom;
      tgt_pool[i] = $urandom;
      case ($urandom_range(0, 3))
        0:       bias[i] = 100;
        1:       bias[i] = 0;
        2:       bias[i] = 85;
        default: bias[i] = $urandom_range(0, 100);
      endcase
    end
    for (int i = 0; i < items; i++) begin
      maybe_pause(pause_pct);
      if ($urandom_range(0, 99) < 12) begin
        w.kind               = 1'($urandom);
        w.pc                 = $urandom;
        w.target_pc          = $urandom;
        w.taken              = 1'($urandom);
        w.earlier_prediction = $urandom;
      end else begin
        k           = $urandom_range(0, pool_n - 1);
        w.kind      = $urandom_range(0, 1) ? KIND_UPDATE : KIND_PREDICT;
        w.pc        = pc_pool[k];
        w.target_pc = ($urandom_range(0, 99) < 85) ? tgt_pool[k] : $urandom;
        w.taken     = ($urandom_range(0, 99) < bias[k]);
        case ($urandom_range(0, 4))
          0, 1:    w.earlier_prediction = w.pc + 32'(PC_STEP);
          2, 3:    w.earlier_prediction = w.target_pc;
          default: w.earlier_prediction = $urandom;
        endcase
      end
      send_word(w);
    end
  endtask

  task automatic test_random_settings();
    int pct;
    for (int p = 0; p < 14; p++) begin
      case (p % 3)
        0:       pct = 0;
        1:       pct = 15;
        default: pct = 40;
      endcase
      run_phase(p, PHASE_WORDS, pct);
    end
  endtask

  task automatic test_back_to_back();
    run_phase(2 + $urandom_range(0, 11), PHASE_WORDS, 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence and watchdog
  // --------------------------------------------------------------------------
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results pending", CYCLE_LIMIT, answer_q.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    mismatch_count  = 0;
    words_sent      = 0;
    results_checked = 0;
    taken_answers   = 0;
    reg_writes      = 0;
    set_log2  = '0;
    set_hist  = 4'd1;
    set_tag   = '0;
    set_init  = CTR_WNT;
    set_gh    = 1'b0;
    set_gt    = 1'b0;
    set_share = SHARE_NONE;
    clear_state();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_counter_saturation();
    test_flush_rule();
    test_tag_change_modes();
    test_random_settings();
    test_back_to_back();
    drain();

    $display("Sent %0d words and %0d register writes; checked %0d results",
             words_sent, reg_writes, results_checked);
    $display("%0d answers predicted taken; %0d field mismatches",
             taken_answers, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
